FILE: hdl/fprm_pkg.sv
package fprm_pkg;

  // field and register widths
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned WAIT_W    = 17;
  localparam int unsigned RATE_W    = 24;

  // divider width: 200000*(n-1) + span stays below 2^33
  localparam int unsigned DIV_W = TIME_W + 1;

  // default ring depth
  localparam int unsigned WINDOW_DEPTH_DEF = 128;

  // register reset values
  localparam logic [CFG_W-1:0] TARGET_FPS_RST      = 8'd60;
  localparam logic [CFG_W-1:0] WINDOW_LEN_RST      = 8'd120;
  localparam logic [CFG_W-1:0] UPDATE_INTERVAL_RST = 8'd60;

  // arithmetic constants
  localparam int unsigned MIN_LEN    = 2;
  localparam int unsigned MS_PER_S   = 1000;
  localparam int unsigned RATE_SCALE = 200000;

  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_FPS      = 2'd0,
    CFG_WINDOW_LEN      = 2'd1,
    CFG_UPDATE_INTERVAL = 2'd2
  } cfg_idx_e;

endpackage

FILE: hdl/fprm_if.sv
interface fprm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [fprm_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, output action, output now_ms, input ready);
  modport sink   (input valid, input action, input now_ms, output ready);
endinterface

interface fprm_out_if;
  logic                          valid;
  logic                          ready;
  logic [fprm_pkg::WAIT_W-1:0]   wait_ms;
  logic [fprm_pkg::RATE_W-1:0]   rate_centi;
  logic                          rate_updated;

  modport source (output valid, output wait_ms, output rate_centi, output rate_updated,
                  input ready);
  modport sink   (input valid, input wait_ms, input rate_centi, input rate_updated,
                  output ready);
endinterface

FILE: hdl/frame_pacer_and_rate_meter_unit.sv
// sequence: a wait request passes S_READ, S_LOAD, S_DIV, S_DONE; a frame stamp that
//   triggers a rate measurement S_PUSH, S_READ, S_LOAD, S_DIV, S_DONE (no S_DIV when the
//   span is zero), any other S_PUSH, S_DONE; the next item is taken only once the last
//   result is registered; one restoring divider, one quotient bit per cycle, serves both
// reset: asynchronous, active low; clears the window, counters, measured rate and
//   registers to their defaults; the stamp memory is not cleared and needs no sweep
module frame_pacer_and_rate_meter_unit #(
  parameter int unsigned WINDOW_DEPTH = fprm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fprm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fprm_pkg::CFG_W-1:0]     cfg_data_i,
  fprm_in_if.sink                        in_i,
  fprm_out_if.source                     out_o
);

  localparam int unsigned IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned LEN_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = LEN_W + 1;
  localparam int unsigned CMP_W  = (LEN_W > fprm_pkg::CFG_W) ? LEN_W : fprm_pkg::CFG_W;
  localparam int unsigned DIV_W  = fprm_pkg::DIV_W;
  localparam int unsigned CNT_W  = $clog2(DIV_W);
  localparam int unsigned TIME_W = fprm_pkg::TIME_W;
  localparam int unsigned CFG_W  = fprm_pkg::CFG_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PUSH = 6'b000010,
    S_READ = 6'b000100,
    S_LOAD = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  // configuration registers
  logic [CFG_W-1:0] fps_q, wlen_q, intv_q;

  // control state
  state_e                        state_q, state_d;
  logic                          act_q, act_d;
  logic                          upd_q, upd_d;
  logic [IDX_W-1:0]              oldest_q, oldest_d;
  logic [LEN_W-1:0]              fill_q, fill_d;
  logic [CFG_W-1:0]              fc_q, fc_d;
  logic [fprm_pkg::RATE_W-1:0]   rate_q, rate_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;

  // payload registers
  logic [TIME_W-1:0]             now_q, now_d;
  logic [TIME_W-1:0]             diff_q, diff_d;
  logic [DIV_W-1:0]              dvd_q, dvd_d;
  logic [DIV_W-1:0]              rem_q, rem_d;
  logic [DIV_W-1:0]              dvs_q, dvs_d;
  logic [fprm_pkg::WAIT_W-1:0]   wait_out_q, wait_out_d;
  logic [fprm_pkg::RATE_W-1:0]   rate_out_q, rate_out_d;
  logic                          updf_out_q, updf_out_d;

  // stamp ring
  logic [TIME_W-1:0]             ring_mem [WINDOW_DEPTH];
  logic [TIME_W-1:0]             rd_q;
  logic                          ring_we;
  logic [IDX_W-1:0]              wr_addr;

  // effective register values
  logic [CFG_W-1:0]              fps_eff, intv_eff;
  logic [CMP_W-1:0]              wlen_ext, len_cmp;
  logic [LEN_W-1:0]              len_eff;

  // push arithmetic
  logic [SUM_W-1:0]              wr_sum, fill_inc, excess, old_sum, fill_new;
  logic [IDX_W-1:0]              oldest_new;
  logic [CFG_W-1:0]              fc_inc;
  logic                          fire;

  // divider step
  logic [DIV_W:0]                trial, trial_sub;
  logic                          trial_ge;

  // result arithmetic
  logic [TIME_W-1:0]             diff_now;
  logic [DIV_W-1:0]              diff_ext, wait_full;
  logic [fprm_pkg::WAIT_W-1:0]   wait_val;
  logic [fprm_pkg::RATE_W-1:0]   rate_new;
  logic                          out_free;

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.wait_ms      = wait_out_q;
  assign out_o.rate_centi   = rate_out_q;
  assign out_o.rate_updated = updf_out_q;

  // clamp register values
  always_comb begin
    fps_eff  = (fps_q == '0) ? CFG_W'(1) : fps_q;
    intv_eff = (intv_q == '0) ? CFG_W'(1) : intv_q;
    wlen_ext = CMP_W'(wlen_q);
    if (wlen_ext < CMP_W'(fprm_pkg::MIN_LEN)) begin
      len_cmp = CMP_W'(fprm_pkg::MIN_LEN);
    end else if (wlen_ext > CMP_W'(WINDOW_DEPTH)) begin
      len_cmp = CMP_W'(WINDOW_DEPTH);
    end else begin
      len_cmp = wlen_ext;
    end
    len_eff = LEN_W'(len_cmp);
  end

  // ring push: write slot, trim oldest stamps beyond the window length
  always_comb begin
    wr_sum = SUM_W'(oldest_q) + SUM_W'(fill_q);
    if (wr_sum >= SUM_W'(WINDOW_DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(WINDOW_DEPTH);
    end
    wr_addr  = IDX_W'(wr_sum);
    fill_inc = SUM_W'(fill_q) + SUM_W'(1);
    excess   = '0;
    fill_new = fill_inc;
    if (fill_inc > SUM_W'(len_eff)) begin
      excess   = fill_inc - SUM_W'(len_eff);
      fill_new = SUM_W'(len_eff);
    end
    old_sum = SUM_W'(oldest_q) + excess;
    if (old_sum >= SUM_W'(WINDOW_DEPTH)) begin
      old_sum = old_sum - SUM_W'(WINDOW_DEPTH);
    end
    oldest_new = IDX_W'(old_sum);
    fc_inc     = fc_q + CFG_W'(1);
    fire       = (fc_inc >= intv_eff);
  end

  // one restoring division step
  always_comb begin
    trial     = {rem_q, dvd_q[DIV_W-1]};
    trial_ge  = (trial >= {1'b0, dvs_q});
    trial_sub = trial - {1'b0, dvs_q};
  end

  // result values
  always_comb begin
    diff_now = now_q - rd_q;
    diff_ext = DIV_W'(diff_q);
    wait_full = '0;
    if (!act_q && (fill_q != '0) && (dvd_q > diff_ext)) begin
      wait_full = dvd_q - diff_ext;
    end
    if (wait_full > DIV_W'(fprm_pkg::WAIT_MAX)) begin
      wait_val = fprm_pkg::WAIT_MAX;
    end else begin
      wait_val = fprm_pkg::WAIT_W'(wait_full);
    end
    if (dvd_q > DIV_W'(fprm_pkg::RATE_MAX)) begin
      rate_new = fprm_pkg::RATE_MAX;
    end else begin
      rate_new = fprm_pkg::RATE_W'(dvd_q);
    end
    out_free = !out_valid_q || out_o.ready;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    upd_d       = upd_q;
    oldest_d    = oldest_q;
    fill_d      = fill_q;
    fc_d        = fc_q;
    rate_d      = rate_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    now_d       = now_q;
    diff_d      = diff_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    wait_out_d  = wait_out_q;
    rate_out_d  = rate_out_q;
    updf_out_d  = updf_out_q;
    ring_we     = 1'b0;

    // result taken downstream
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d   = in_i.action;
          now_d   = in_i.now_ms;
          upd_d   = 1'b0;
          state_d = in_i.action ? S_PUSH : S_READ;
        end
      end
      S_PUSH: begin
        ring_we  = 1'b1;
        oldest_d = oldest_new;
        fill_d   = LEN_W'(fill_new);
        fc_d     = fire ? '0 : fc_inc;
        if (fire && (fill_new >= SUM_W'(len_eff))) begin
          upd_d   = 1'b1;
          state_d = S_READ;
        end else begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        diff_d = diff_now;
        rem_d  = '0;
        cnt_d  = CNT_W'(DIV_W - 1);
        if (!act_q) begin
          dvd_d   = DIV_W'(fill_q) * DIV_W'(fprm_pkg::MS_PER_S);
          dvs_d   = DIV_W'(fps_eff);
          state_d = S_DIV;
        end else if (diff_now == '0) begin
          upd_d   = 1'b0;
          state_d = S_DONE;
        end else begin
          dvd_d   = DIV_W'(fill_q - LEN_W'(1)) * DIV_W'(fprm_pkg::RATE_SCALE)
                    + DIV_W'(diff_now);
          dvs_d   = {diff_now, 1'b0};
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = trial_ge ? DIV_W'(trial_sub) : DIV_W'(trial);
        dvd_d = {dvd_q[DIV_W-2:0], trial_ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (upd_q) begin
            rate_d = rate_new;
          end
          out_valid_d = 1'b1;
          wait_out_d  = wait_val;
          rate_out_d  = upd_q ? rate_new : rate_q;
          updf_out_d  = upd_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q  <= fprm_pkg::TARGET_FPS_RST;
      wlen_q <= fprm_pkg::WINDOW_LEN_RST;
      intv_q <= fprm_pkg::UPDATE_INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (fprm_pkg::cfg_idx_e'(cfg_idx_i))
        fprm_pkg::CFG_TARGET_FPS:      fps_q  <= cfg_data_i;
        fprm_pkg::CFG_WINDOW_LEN:      wlen_q <= cfg_data_i;
        fprm_pkg::CFG_UPDATE_INTERVAL: intv_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= 1'b0;
      upd_q       <= 1'b0;
      oldest_q    <= '0;
      fill_q      <= '0;
      fc_q        <= '0;
      rate_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      upd_q       <= upd_d;
      oldest_q    <= oldest_d;
      fill_q      <= fill_d;
      fc_q        <= fc_d;
      rate_q      <= rate_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    diff_q     <= diff_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    wait_out_q <= wait_out_d;
    rate_out_q <= rate_out_d;
    updf_out_q <= updf_out_d;
  end

  // stamp memory, registered read of the oldest stamp
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wr_addr] <= now_q;
    end
    rd_q <= ring_mem[oldest_q];
  end

endmodule

FILE: hdl/fprm_checker.sv
module fprm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [fprm_pkg::WAIT_W-1:0]   out_wait_ms_i,
  input logic [fprm_pkg::RATE_W-1:0]   out_rate_centi_i,
  input logic                          out_rate_updated_i
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_wait_ms_i)
      && $stable(out_rate_centi_i) && $stable(out_rate_updated_i))
    else $error("stalled result changed");

  // one item at a time: no acceptance right after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while busy");

  // a fresh rate only comes from a frame stamp, which carries no wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rate_updated_i |-> out_wait_ms_i == '0)
    else $error("rate update with nonzero wait");

  // no result is offered while reset is held
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind frame_pacer_and_rate_meter_unit fprm_checker u_fprm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_wait_ms_i      (out_o.wait_ms),
  .out_rate_centi_i   (out_o.rate_centi),
  .out_rate_updated_i (out_o.rate_updated)
);

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned DEPTH       = fprm_pkg::WINDOW_DEPTH_DEF;
  localparam int unsigned SLOT_W      = $clog2(DEPTH);
  localparam int unsigned TIME_W      = fprm_pkg::TIME_W;
  localparam int unsigned CFG_W       = fprm_pkg::CFG_W;
  localparam int unsigned WAIT_W      = fprm_pkg::WAIT_W;
  localparam int unsigned RATE_W      = fprm_pkg::RATE_W;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned END_SETTLE  = 40;
  localparam int unsigned PEND_W      = 3;
  localparam int unsigned PEND_DEPTH  = 1 << PEND_W;
  localparam int          PHASES      = 12;
  localparam int          PHASE_ITEMS = 125;

  // item actions
  localparam logic ACT_WAIT  = 1'b0;
  localparam logic ACT_STAMP = 1'b1;

  // register indexes used by the table
  localparam fprm_pkg::cfg_idx_e R_FPS  = fprm_pkg::CFG_TARGET_FPS;
  localparam fprm_pkg::cfg_idx_e R_LEN  = fprm_pkg::CFG_WINDOW_LEN;
  localparam fprm_pkg::cfg_idx_e R_INTV = fprm_pkg::CFG_UPDATE_INTERVAL;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_e;

  typedef struct packed {
    logic [WAIT_W-1:0] wait_ms;
    logic [RATE_W-1:0] rate_centi;
    logic              rate_updated;
  } frame_result_t;

  typedef struct packed {
    row_kind_e          kind;
    fprm_pkg::cfg_idx_e reg_sel;
    logic [CFG_W-1:0]   reg_val;
    logic               act;
    logic [TIME_W-1:0]  t;
    logic               pinned;
    frame_result_t      pinned_res;
  } probe_row_t;

  // directed walk: empty window, clamped registers, wrap, zero span, shrink
  localparam probe_row_t PROBE_PLAN [31] = '{
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_WAIT,  32'h0000_0000, 1'b1, '{17'd0, 24'd0, 1'b0}},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_WAIT,  32'hFFFF_FFFF, 1'b1, '{17'd0, 24'd0, 1'b0}},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_STAMP, 32'h0000_0000, 1'b1, '{17'd0, 24'd0, 1'b0}},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  R_FPS,  8'd0,   ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  R_LEN,  8'd1,   ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  R_INTV, 8'd0,   ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_STAMP, 32'hFFFF_FFF0, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_STAMP, 32'h0000_0010, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_WAIT,  32'h0000_0010, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_WAIT,  32'h8000_0000, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_STAMP, 32'h0000_0010, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_STAMP, 32'h0000_0011, 1'b0, '0},
    '{ROW_CFG,  R_LEN,  8'd255, ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  R_INTV, 8'd255, ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  R_FPS,  8'd255, ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_STAMP, 32'h0000_0020, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_STAMP, 32'h0000_0030, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_STAMP, 32'h0000_0040, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_WAIT,  32'h0000_0040, 1'b0, '0},
    '{ROW_CFG,  R_LEN,  8'd0,   ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  R_INTV, 8'd2,   ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_STAMP, 32'h0000_0044, 1'b0, '0},
    '{ROW_CFG,  R_FPS,  8'd240, ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  R_LEN,  8'd128, ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  R_INTV, 8'd1,   ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_WAIT,  32'h0000_0044, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_STAMP, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_WAIT,  32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_CFG,  R_FPS,  8'd1,   ACT_WAIT,  32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, R_FPS,  8'd0,   ACT_WAIT,  32'h0000_0100, 1'b0, '0}
  };

  // register settings per random phase, -1 picks a random typical value
  localparam int FPS_PLAN  [PHASES] = '{60, 1, 240, 255, 0, -1, -1, 30, -1, 1, 240, -1};
  localparam int LEN_PLAN  [PHASES] = '{4, 2, 128, 255, 1, 8, -1, 0, 3, 128, 255, -1};
  localparam int INTV_PLAN [PHASES] = '{1, 3, 255, 7, 0, 2, -1, 1, 5, 60, 1, -1};

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [fprm_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  fprm_in_if  in_ch ();
  fprm_out_if out_ch ();

  frame_pacer_and_rate_meter_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pacer state mirror
  logic [CFG_W-1:0]  fps_reg;
  logic [CFG_W-1:0]  len_reg;
  logic [CFG_W-1:0]  intv_reg;
  logic [TIME_W-1:0] stamp_mem [DEPTH];
  logic [SLOT_W-1:0] oldest_slot;
  logic [7:0]        held_cnt;
  logic [7:0]        frames_cnt;
  logic [RATE_W-1:0] rate_now;

  // results still owed by the block, oldest first
  frame_result_t     pend_mem [PEND_DEPTH];
  int unsigned       pend_wr;
  int unsigned       pend_rd;

  frame_result_t     want;
  int                fails;
  int unsigned       quiet_cycles;
  int                src_idle_pct;
  int                snk_idle_pct;
  logic [TIME_W-1:0] clock_ms;

  function automatic int unsigned pend_count();
    return pend_wr - pend_rd;
  endfunction

  function automatic void pend_add(input frame_result_t r);
    if (pend_count() >= PEND_DEPTH) begin
      $error("too many results outstanding: %0d", pend_count());
      fails++;
    end
    pend_mem[pend_wr[PEND_W-1:0]] = r;
    pend_wr++;
  endfunction

  function automatic frame_result_t pend_take();
    frame_result_t r;
    r = pend_mem[pend_rd[PEND_W-1:0]];
    pend_rd++;
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input int unsigned offset);
    return SLOT_W'((oldest_slot + offset) % DEPTH);
  endfunction

  // next result of the pacer, advancing the mirrored state
  function automatic frame_result_t pace_step(input logic act, input logic [TIME_W-1:0] t);
    int unsigned       len;
    int unsigned       fps;
    int unsigned       intv;
    int unsigned       held;
    longint unsigned   due;
    longint unsigned   gone;
    longint unsigned   left;
    longint unsigned   quot;
    logic [TIME_W-1:0] span;
    frame_result_t     res;
    res = '0;
    len = (len_reg < fprm_pkg::MIN_LEN) ? fprm_pkg::MIN_LEN : len_reg;
    if (len > DEPTH) len = DEPTH;
    if (act == ACT_WAIT) begin
      // time still owed so the window spans n frame periods
      if (held_cnt != 0) begin
        fps  = (fps_reg == 0) ? 1 : fps_reg;
        due  = (longint'(held_cnt) * fprm_pkg::MS_PER_S) / fps;
        span = t - stamp_mem[oldest_slot];
        gone = span;
        left = (due > gone) ? due - gone : 0;
        res.wait_ms = (left > fprm_pkg::WAIT_MAX) ? fprm_pkg::WAIT_MAX : left[WAIT_W-1:0];
      end
    end else begin
      // push the stamp, dropping every stamp beyond the window length
      intv = (intv_reg == 0) ? 1 : intv_reg;
      frames_cnt = frames_cnt + 8'd1;
      stamp_mem[slot_of(held_cnt)] = t;
      held = held_cnt + 1;
      if (held > len) begin
        oldest_slot = slot_of(held - len);
        held = len;
      end
      held_cnt = held[7:0];
      // rate over a full window, kept when the span is zero
      if (frames_cnt >= intv) begin
        if (held_cnt != 0 && held_cnt >= len) begin
          span = stamp_mem[slot_of(held_cnt - 1)] - stamp_mem[oldest_slot];
          if (span != 0) begin
            quot = (longint'(fprm_pkg::RATE_SCALE) * (held_cnt - 1) + span)
                   / (2 * longint'(span));
            rate_now = (quot > fprm_pkg::RATE_MAX) ? fprm_pkg::RATE_MAX : quot[RATE_W-1:0];
            res.rate_updated = 1'b1;
          end
        end
        frames_cnt = '0;
      end
    end
    res.rate_centi = rate_now;
    return res;
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        src_idle_pct = 29;
        snk_idle_pct = 57;
      end
      1: begin
        src_idle_pct = 57;
        snk_idle_pct = 29;
      end
      default: begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
    endcase
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic settle(input int unsigned cycles);
    in_ch.valid <= 1'b0;
    while (pend_count() != 0) @(negedge clk_i);
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input fprm_pkg::cfg_idx_e idx, input logic [CFG_W-1:0] val);
    settle(4);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      fprm_pkg::CFG_TARGET_FPS:      fps_reg  = val;
      fprm_pkg::CFG_WINDOW_LEN:      len_reg  = val;
      fprm_pkg::CFG_UPDATE_INTERVAL: intv_reg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one item, entered and left just after a falling edge
  task automatic send_item(input logic act, input logic [TIME_W-1:0] t, input logic pinned,
                           input frame_result_t pinned_res);
    frame_result_t got;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.now_ms <= t;
    do @(posedge clk_i); while (!in_ch.ready);
    got = pace_step(act, t);
    pend_add(pinned ? pinned_res : got);
    @(negedge clk_i);
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pend_count() == 0) begin
        $error("result item with none expected: wait_ms %0d rate_centi %0d rate_updated %0d",
               out_ch.wait_ms, out_ch.rate_centi, out_ch.rate_updated);
        fails++;
      end else begin
        want = pend_take();
        if (out_ch.wait_ms !== want.wait_ms) begin
          $error("wait_ms: expected %0d, got %0d", want.wait_ms, out_ch.wait_ms);
          fails++;
        end
        if (out_ch.rate_centi !== want.rate_centi) begin
          $error("rate_centi: expected %0d, got %0d", want.rate_centi, out_ch.rate_centi);
          fails++;
        end
        if (out_ch.rate_updated !== want.rate_updated) begin
          $error("rate_updated: expected %0d, got %0d", want.rate_updated, out_ch.rate_updated);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int          roll;
    int          pick;
    logic        act;
    logic [TIME_W-1:0] t;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_WAIT;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    fails        = 0;
    quiet_cycles = 0;
    pend_wr      = 0;
    pend_rd      = 0;
    fps_reg      = fprm_pkg::TARGET_FPS_RST;
    len_reg      = fprm_pkg::WINDOW_LEN_RST;
    intv_reg     = fprm_pkg::UPDATE_INTERVAL_RST;
    oldest_slot  = '0;
    held_cnt     = '0;
    frames_cnt   = '0;
    rate_now     = '0;
    clock_ms     = $urandom();
    set_idling(0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed walk
    foreach (PROBE_PLAN[k]) begin
      if (PROBE_PLAN[k].kind == ROW_CFG) begin
        write_reg(PROBE_PLAN[k].reg_sel, PROBE_PLAN[k].reg_val);
      end else begin
        send_item(PROBE_PLAN[k].act, PROBE_PLAN[k].t, PROBE_PLAN[k].pinned,
                  PROBE_PLAN[k].pinned_res);
      end
    end

    // random phases: mostly steady frame times with interleaved wait requests
    for (int ph = 0; ph < PHASES; ph++) begin
      set_idling(ph / 4);
      pick = FPS_PLAN[ph];
      write_reg(fprm_pkg::CFG_TARGET_FPS,
                (pick < 0) ? CFG_W'($urandom_range(1, 240)) : CFG_W'(pick));
      pick = LEN_PLAN[ph];
      write_reg(fprm_pkg::CFG_WINDOW_LEN,
                (pick < 0) ? CFG_W'($urandom_range(2, 16)) : CFG_W'(pick));
      pick = INTV_PLAN[ph];
      write_reg(fprm_pkg::CFG_UPDATE_INTERVAL,
                (pick < 0) ? CFG_W'($urandom_range(1, 8)) : CFG_W'(pick));
      // run some phases across the time counter wrap
      if (ph % 4 == 2) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          act = $urandom_range(1);
          t   = $urandom();
        end else begin
          act = (roll < 68) ? ACT_STAMP : ACT_WAIT;
          clock_ms += ($urandom_range(19) == 0) ? $urandom_range(200000) : $urandom_range(40);
          t = clock_ms;
        end
        send_item(act, t, 1'b0, '0);
      end
    end

    settle(END_SETTLE);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
